[rtl/vlmd_pkg.sv]
// vlmd_pkg: shared types and constants of the volume local maximum detector.
// Depends on nothing; imported by the top level, the delay line and the checker.
package vlmd_pkg;

	localparam int VAL_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int POS_X_W    = 8;
	localparam int POS_Y_W    = 8;
	localparam int POS_Z_W    = 10;

	typedef logic signed [VAL_W-1:0] voxel_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_WIDTH     = 2'd0;
	localparam cfg_idx_t REG_HEIGHT    = 2'd1;
	localparam cfg_idx_t REG_DEPTH     = 2'd2;
	localparam cfg_idx_t REG_THRESHOLD = 2'd3;

	typedef struct packed {
		logic adv;
		logic clr;
	} dly_ctrl_t;

endpackage

[rtl/vlmd_delay.sv]
// vlmd_delay: programmable voxel delay line on a single-port circular memory.
// Delay is len+1 beats; len of zero uses the bypass register. Uses vlmd_pkg.
module vlmd_delay #(
	parameter int DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vlmd_pkg::dly_ctrl_t       ctrl,
	input  logic [$clog2(DEPTH)-1:0]  len,
	input  vlmd_pkg::voxel_t          din,
	output vlmd_pkg::voxel_t          dout
);
	import vlmd_pkg::*;

	localparam int AW = $clog2(DEPTH);

	voxel_t mem [DEPTH];
	logic [AW-1:0] ptr_q;
	voxel_t rd_q;
	voxel_t byp_q;
	logic len_zero;

	assign len_zero = (len == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctrl.clr) begin
			ptr_q <= '0;
		end else if (ctrl.adv && !len_zero) begin
			if (ptr_q == len - AW'(1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv && !len_zero) begin
			rd_q <= mem[ptr_q];
			mem[ptr_q] <= din;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			byp_q <= din;
		end
	end

	assign dout = len_zero ? byp_q : rd_q;

endmodule

[rtl/volume_local_maximum_detector.sv]
// Latency: a voxel's result is registered at the accept of the item that lies
// width*height+width+1 beats later in the stream, into the output register or the skid entry.
// Throughput: one item per cycle unless stalled; plane and row delay memories
// each do one read and one write per beat; a two-entry output buffer holds results.
// Reset: asynchronous, clears counters and output valids, geometry to defaults;
// delay memories are not cleared, only entries written in the volume are used.
module volume_local_maximum_detector #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_DEPTH  = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  vlmd_pkg::voxel_t                 voxel_value,
	input  logic                             drain,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [vlmd_pkg::POS_X_W-1:0]     pos_x,
	output logic [vlmd_pkg::POS_Y_W-1:0]     pos_y,
	output logic [vlmd_pkg::POS_Z_W-1:0]     pos_z,
	output vlmd_pkg::voxel_t                 peak_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  vlmd_pkg::cfg_idx_t               cfg_index,
	input  vlmd_pkg::cfg_data_t              cfg_data
);
	import vlmd_pkg::*;

	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int HW        = $clog2(MAX_HEIGHT + 1);
	localparam int DW        = $clog2(MAX_DEPTH + 1);
	localparam int PLANE_MAX = MAX_WIDTH * MAX_HEIGHT;
	localparam int PW        = $clog2(PLANE_MAX + 1);
	localparam int LW        = $clog2(PLANE_MAX + MAX_WIDTH + 2);
	localparam int ROW_AW    = $clog2(MAX_WIDTH);
	localparam int PLANE_AW  = $clog2(PLANE_MAX);

	function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] maxv);
		logic [31:0] r;
		if (v == 32'd0) begin
			r = 32'd1;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	localparam logic [31:0] W_RST = clamp_dim(32'd256, 32'(MAX_WIDTH));
	localparam logic [31:0] H_RST = clamp_dim(32'd256, 32'(MAX_HEIGHT));
	localparam logic [31:0] D_RST = clamp_dim(32'd1024, 32'(MAX_DEPTH));

	typedef struct packed {
		logic [POS_X_W-1:0] x;
		logic [POS_Y_W-1:0] y;
		logic [POS_Z_W-1:0] z;
		voxel_t             value;
	} peak_t;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [DW-1:0] d_q;
	logic [PW-1:0] wh_q;
	voxel_t        thr_q;

	logic [WW-1:0] new_w;
	logic [HW-1:0] new_h;
	logic [DW-1:0] new_d;
	logic          cfg_wr;
	logic          geo_wr;

	logic [WW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [DW-1:0] plane_q;
	logic [LW-1:0] lead_q;
	logic [LW-1:0] tail_q;
	logic [WW-1:0] ccx_q;
	logic [HW-1:0] ccy_q;
	logic [DW-1:0] ccz_q;

	logic [LW-1:0] lag;
	logic          acc;
	logic          done;
	logic          adv;
	logic          restart;
	logic          decide;
	logic [LW-1:0] lead_b;
	logic [WW-1:0] col_b;
	logic [HW-1:0] row_b;
	logic [DW-1:0] plane_b;

	dly_ctrl_t           dly_ctrl;
	logic [ROW_AW-1:0]   row_len;
	logic [PLANE_AW-1:0] plane_len;
	voxel_t              plane_tap [3];
	voxel_t              tap [3][3];
	voxel_t              win0_q [3][3];
	voxel_t              win1_q [3][3];

	voxel_t center;
	logic   x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
	logic   nb_ok;
	logic   res_valid;
	peak_t  res;

	logic  out_valid_q;
	logic  skid_valid_q;
	peak_t out_q;
	peak_t skid_q;
	logic  out_fire;
	logic  take_skid;
	logic  take_res;
	logic  park;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign geo_wr    = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_DEPTH);
	assign new_w = WW'(clamp_dim({23'd0, cfg_data[8:0]}, 32'(MAX_WIDTH)));
	assign new_h = HW'(clamp_dim({23'd0, cfg_data[8:0]}, 32'(MAX_HEIGHT)));
	assign new_d = DW'(clamp_dim({21'd0, cfg_data[10:0]}, 32'(MAX_DEPTH)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WW'(W_RST);
			h_q   <= HW'(H_RST);
			d_q   <= DW'(D_RST);
			wh_q  <= PW'(W_RST * H_RST);
			thr_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					w_q  <= new_w;
					wh_q <= PW'(new_w) * PW'(h_q);
				end
				REG_HEIGHT: begin
					h_q  <= new_h;
					wh_q <= PW'(w_q) * PW'(new_h);
				end
				REG_DEPTH: begin
					d_q <= new_d;
				end
				REG_THRESHOLD: begin
					thr_q <= voxel_t'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// stream position
	assign lag     = LW'(wh_q) + LW'(w_q) + LW'(1);
	assign acc     = in_valid && !in_stall;
	assign done    = (plane_q == d_q);
	assign adv     = acc && (!drain || (done && tail_q != lag));
	assign restart = acc && !drain && done;
	assign lead_b  = restart ? '0 : lead_q;
	assign col_b   = restart ? '0 : col_q;
	assign row_b   = restart ? '0 : row_q;
	assign plane_b = restart ? '0 : plane_q;
	assign decide  = adv && (lead_b == lag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			lead_q  <= '0;
			tail_q  <= '0;
			ccx_q   <= '0;
			ccy_q   <= '0;
			ccz_q   <= '0;
		end else if (geo_wr) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			lead_q  <= '0;
			tail_q  <= '0;
			ccx_q   <= '0;
			ccy_q   <= '0;
			ccz_q   <= '0;
		end else if (adv) begin
			if (restart) begin
				tail_q <= '0;
			end
			if (drain) begin
				tail_q <= tail_q + LW'(1);
			end else if (col_b + WW'(1) == w_q) begin
				col_q <= '0;
				if (row_b + HW'(1) == h_q) begin
					row_q   <= '0;
					plane_q <= plane_b + DW'(1);
				end else begin
					row_q   <= row_b + HW'(1);
					plane_q <= plane_b;
				end
			end else begin
				col_q   <= col_b + WW'(1);
				row_q   <= row_b;
				plane_q <= plane_b;
			end
			if (!decide) begin
				lead_q <= lead_b + LW'(1);
			end
			if (restart) begin
				ccx_q <= '0;
				ccy_q <= '0;
				ccz_q <= '0;
			end else if (decide) begin
				if (x_hi) begin
					ccx_q <= ccx_q + WW'(1);
				end else begin
					ccx_q <= '0;
					if (y_hi) begin
						ccy_q <= ccy_q + HW'(1);
					end else begin
						ccy_q <= '0;
						ccz_q <= ccz_q + DW'(1);
					end
				end
			end
		end
	end

	// plane and row delay lines: tap[a][b] is the voxel a planes and b rows back
	assign dly_ctrl.adv = adv;
	assign dly_ctrl.clr = geo_wr;
	assign row_len      = ROW_AW'(w_q - WW'(1));
	assign plane_len    = PLANE_AW'(wh_q - PW'(1));
	assign plane_tap[0] = voxel_value;

	for (genvar g = 1; g < 3; g++) begin : g_plane
		vlmd_delay #(
			.DEPTH(PLANE_MAX)
		) u_plane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (dly_ctrl),
			.len   (plane_len),
			.din   (plane_tap[g-1]),
			.dout  (plane_tap[g])
		);
	end

	for (genvar a = 0; a < 3; a++) begin : g_lvl
		assign tap[a][0] = plane_tap[a];
		for (genvar b = 1; b < 3; b++) begin : g_row
			vlmd_delay #(
				.DEPTH(MAX_WIDTH)
			) u_row (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (dly_ctrl),
				.len   (row_len),
				.din   (tap[a][b-1]),
				.dout  (tap[a][b])
			);
		end
	end

	// 3x3x3 window: tap is the leading column, win0 the center, win1 the trailing
	always_ff @(posedge clk) begin
		if (adv) begin
			win1_q <= win0_q;
			win0_q <= tap;
		end
	end

	assign center = win0_q[1][1];
	assign x_lo   = (ccx_q != '0);
	assign x_hi   = (WW'(ccx_q + WW'(1)) != w_q);
	assign y_lo   = (ccy_q != '0);
	assign y_hi   = (HW'(ccy_q + HW'(1)) != h_q);
	assign z_lo   = (ccz_q != '0);
	assign z_hi   = (DW'(ccz_q + DW'(1)) != d_q);

	always_comb begin
		logic zok;
		logic yok;
		nb_ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				zok = (a == 0) ? z_hi : ((a == 2) ? z_lo : 1'b1);
				yok = (b == 0) ? y_hi : ((b == 2) ? y_lo : 1'b1);
				if (zok && yok && x_hi && (tap[a][b] > center)) begin
					nb_ok = 1'b0;
				end
				if (zok && yok && x_lo && (win1_q[a][b] > center)) begin
					nb_ok = 1'b0;
				end
				if (zok && yok && !(a == 1 && b == 1) && (win0_q[a][b] > center)) begin
					nb_ok = 1'b0;
				end
			end
		end
	end

	assign res_valid = decide && (center > thr_q) && nb_ok;
	assign res.x     = POS_X_W'(32'(ccx_q));
	assign res.y     = POS_Y_W'(32'(ccy_q));
	assign res.z     = POS_Z_W'(32'(ccz_q));
	assign res.value = center;

	// output register with skid entry
	assign out_fire  = out_valid_q && !out_stall;
	assign take_skid = skid_valid_q && out_fire;
	assign take_res  = !skid_valid_q && (!out_valid_q || out_fire);
	assign park      = !skid_valid_q && out_valid_q && !out_fire && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take_skid) begin
				skid_valid_q <= 1'b0;
			end else if (take_res) begin
				out_valid_q <= res_valid;
			end else if (park) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_skid) begin
			out_q <= skid_q;
		end else if (take_res) begin
			out_q <= res;
		end
		if (park) begin
			skid_q <= res;
		end
	end

	assign in_stall   = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign pos_x      = out_q.x;
	assign pos_y      = out_q.y;
	assign pos_z      = out_q.z;
	assign peak_value = out_q.value;

endmodule

[rtl/vlmd_checker.sv]
// vlmd_checker: port-level assertions for the volume local maximum detector,
// bound to the top level below. Uses vlmd_pkg.
module vlmd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [vlmd_pkg::POS_X_W-1:0]     pos_x,
	input logic [vlmd_pkg::POS_Y_W-1:0]     pos_y,
	input logic [vlmd_pkg::POS_Z_W-1:0]     pos_z,
	input vlmd_pkg::voxel_t                 peak_value
);
	import vlmd_pkg::*;

	// input backpressure only while a result waits behind the output beat
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output beat pending");

	// no output beat appears without an accepted input beat
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !(in_valid && !in_stall)) |=> !out_valid)
		else $error("output beat without an accepted input beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output beat dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(peak_value)))
		else $error("stalled output beat changed");

endmodule

bind volume_local_maximum_detector vlmd_checker u_vlmd_checker (.*);
